FILE: sv/linear_adsr_cutoff_envelope_top_assert.svh
// Assertion macros shared by the envelope RTL.
// Depends on nothing; a file that asserts includes it ahead of its module.
`ifndef LINEAR_ADSR_CUTOFF_ENVELOPE_TOP_ASSERT_SVH
`define LINEAR_ADSR_CUTOFF_ENVELOPE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low.
`define LADSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define LADSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LADSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define LADSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: sv/ladsr_pkg.sv
// Shared types, codes and helper functions for the ADSR cutoff envelope.
// No dependencies; imported by every module of the block.
package ladsr_pkg;

    localparam int BASE_W     = 15;
    localparam int AMT_W      = 16;
    localparam int SUS_W      = 16;
    localparam int LEN_CFG_W  = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int OP_W       = 3;
    localparam int PH_W       = 2;
    localparam int W25        = 25;
    localparam int X_W        = 17;
    localparam int PROD_W     = 32;
    localparam int QX_W       = 33;
    localparam int SUM_W      = 34;

    localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_W-1:0] OP_NOTE    = 3'd1;
    localparam logic [OP_W-1:0] OP_REL_ON  = 3'd2;
    localparam logic [OP_W-1:0] OP_REL_OFF = 3'd3;
    localparam logic [OP_W-1:0] OP_FORCE   = 3'd4;

    localparam logic [PH_W-1:0] PH_ATTACK  = 2'd0;
    localparam logic [PH_W-1:0] PH_DECAY   = 2'd1;
    localparam logic [PH_W-1:0] PH_SUSTAIN = 2'd2;
    localparam logic [PH_W-1:0] PH_RELEASE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd5;

    // Which of the three segment steps the shared divider is working on.
    localparam logic [1:0] SEL_ATT = 2'd0;
    localparam logic [1:0] SEL_DEC = 2'd1;
    localparam logic [1:0] SEL_REL = 2'd2;

    localparam logic [X_W-1:0] UNITY_Q16 = 17'h10000;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2**(W25-1) - 1);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2**(W25-1)));
    localparam logic [QX_W-1:0] QLIM_POS = QX_W'(2**(W25-1) - 1);
    localparam logic [QX_W-1:0] QLIM_NEG = QX_W'(2**(W25-1));

    typedef struct packed {
        logic [BASE_W-1:0]    base;
        logic [AMT_W-1:0]     amt;
        logic [SUS_W-1:0]     sus;
        logic [LEN_CFG_W-1:0] att_len;
        logic [LEN_CFG_W-1:0] dec_len;
        logic [LEN_CFG_W-1:0] rel_len;
    } t_cfg;

    typedef struct packed {
        logic       accept;
        logic       exec;
        logic       mul_load;
        logic       div_start;
        logic       step_store;
        logic [1:0] sel;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic note_start;
        logic div_done;
    } t_status;

    function automatic logic signed [W25-1:0] sat25(input logic signed [SUM_W-1:0] v);
        logic signed [W25-1:0] res;
        if (v > SAT_HI) begin
            res = SAT_HI[W25-1:0];
        end else if (v < SAT_LO) begin
            res = SAT_LO[W25-1:0];
        end else begin
            res = v[W25-1:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/linear_adsr_cutoff_envelope_top.sv
// A transaction is captured when accepted and applied in the execute state, which writes its
// result to the output register once that register has room. The input stalls until the
// transaction is done; a note start also holds it while the shared serial divider, one
// quotient bit per cycle, works out each of the three segment steps in turn.
// Reset (synchronous, active low): sustain phase, zero offset and steps, release flag
// clear, registers at their defaults, output empty.
module linear_adsr_cutoff_envelope_top
    import ladsr_pkg::*;
#(
    parameter int LEN_BITS  = 20,
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_op,
    input  logic [PH_W-1:0]       i_phase_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [W25-1:0] o_cutoff_q8,
    output logic [PH_W-1:0]       o_phase,
    output logic                  o_release_active
);

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    // Writes to an index past the register list fall through and change nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base    <= BASE_W'(1000);
            r_cfg.amt     <= '0;
            r_cfg.sus     <= SUS_W'(32768);
            r_cfg.att_len <= '0;
            r_cfg.dec_len <= '0;
            r_cfg.rel_len <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BASE:    r_cfg.base    <= i_cfg_data[BASE_W-1:0];
                CFG_AMOUNT:  r_cfg.amt     <= i_cfg_data[AMT_W-1:0];
                CFG_SUSTAIN: r_cfg.sus     <= i_cfg_data[SUS_W-1:0];
                CFG_ATTACK:  r_cfg.att_len <= i_cfg_data[LEN_CFG_W-1:0];
                CFG_DECAY:   r_cfg.dec_len <= i_cfg_data[LEN_CFG_W-1:0];
                CFG_RELEASE: r_cfg.rel_len <= i_cfg_data[LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    ladsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ladsr_dp #(
        .LEN_BITS  (LEN_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_op             (i_op),
        .i_phase_value    (i_phase_value),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cutoff_q8      (o_cutoff_q8),
        .o_phase          (o_phase),
        .o_release_active (o_release_active)
    );

endmodule

FILE: sv/ladsr_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Uses ladsr_pkg; instantiated by the envelope datapath.
module ladsr_div
    import ladsr_pkg::*;
#(
    parameter int NUM_W = 24,
    parameter int DEN_W = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

FILE: sv/ladsr_dp.sv
// Envelope datapath: segment counters, offset accumulator, step registers,
// step multiplier with the shared divider, and the result register. Uses ladsr_pkg.
module ladsr_dp
    import ladsr_pkg::*;
#(
    parameter int LEN_BITS  = 20,
    parameter int FRAC_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg                  i_cfg,
    input  logic [OP_W-1:0]       i_op,
    input  logic [PH_W-1:0]       i_phase_value,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [W25-1:0] o_cutoff_q8,
    output logic [PH_W-1:0]       o_phase,
    output logic                  o_release_active
);

    localparam int MAG_W  = 16 + FRAC_BITS;
    localparam int WIDE_W = PROD_W + FRAC_BITS;

    // Captured transaction.
    logic [OP_W-1:0] r_op;
    logic [PH_W-1:0] r_pv;

    // Envelope state.
    logic [PH_W-1:0]       r_phase, n_phase;
    logic                  r_rel, n_rel;
    logic signed [W25-1:0] r_offset, n_offset;
    logic [LEN_BITS-1:0]   r_att_left, n_att_left;
    logic [LEN_BITS-1:0]   r_dec_left, n_dec_left;
    logic [LEN_BITS-1:0]   r_rel_left, n_rel_left;
    logic signed [W25-1:0] r_att_step;
    logic signed [W25-1:0] r_dec_step;
    logic signed [W25-1:0] r_rel_step;

    // Result register.
    logic                  r_out_valid;
    logic signed [W25-1:0] r_cut;
    logic [PH_W-1:0]       r_out_phase;
    logic                  r_out_rel;

    // Step computation.
    logic [PROD_W-1:0]   r_prod;
    logic [AMT_W-1:0]    amt_mag;
    logic [X_W-1:0]      x_sel;
    logic [LEN_BITS-1:0] len_sel;
    logic [WIDE_W-1:0]   wide;
    logic [MAG_W-1:0]    div_num;
    logic [MAG_W-1:0]    div_quo;
    logic                div_done;
    logic [QX_W-1:0]     q_ext;
    logic                amt_neg;
    logic signed [W25-1:0] step_val;

    logic [SUM_W-1:0]        base_ext;
    logic signed [SUM_W-1:0] cut_sum;

    always_comb begin
        base_ext = SUM_W'(i_cfg.base) << FRAC_BITS;
        cut_sum  = $signed(base_ext) + SUM_W'(r_offset);
    end

    // Operation applied to the state when the controller issues exec.
    always_comb begin
        n_phase    = r_phase;
        n_rel      = r_rel;
        n_offset   = r_offset;
        n_att_left = r_att_left;
        n_dec_left = r_dec_left;
        n_rel_left = r_rel_left;
        case (r_op)
            OP_TICK: begin
                case (r_phase)
                    PH_ATTACK: begin
                        n_offset = sat25(SUM_W'(r_offset) + SUM_W'(r_att_step));
                        if (r_att_left <= LEN_BITS'(1)) begin
                            n_phase = PH_DECAY;
                        end
                        if (r_att_left != '0) begin
                            n_att_left = r_att_left - LEN_BITS'(1);
                        end
                    end
                    PH_DECAY: begin
                        n_offset = sat25(SUM_W'(r_offset) - SUM_W'(r_dec_step));
                        if (r_dec_left <= LEN_BITS'(1)) begin
                            n_phase = PH_SUSTAIN;
                        end
                        if (r_dec_left != '0) begin
                            n_dec_left = r_dec_left - LEN_BITS'(1);
                        end
                    end
                    PH_SUSTAIN: begin
                        if (r_rel) begin
                            n_phase = PH_RELEASE;
                        end
                    end
                    default: begin
                        // Release only moves the offset while the flag is set.
                        if (r_rel) begin
                            n_offset = sat25(SUM_W'(r_offset) - SUM_W'(r_rel_step));
                        end
                        if (r_rel_left <= LEN_BITS'(1)) begin
                            n_rel = 1'b0;
                        end
                        if (r_rel_left != '0) begin
                            n_rel_left = r_rel_left - LEN_BITS'(1);
                        end
                    end
                endcase
            end
            OP_NOTE: begin
                n_offset   = '0;
                n_phase    = PH_ATTACK;
                n_att_left = LEN_BITS'({{LEN_BITS{1'b0}}, i_cfg.att_len});
                n_dec_left = LEN_BITS'({{LEN_BITS{1'b0}}, i_cfg.dec_len});
                n_rel_left = LEN_BITS'({{LEN_BITS{1'b0}}, i_cfg.rel_len});
            end
            OP_REL_ON:  n_rel = 1'b1;
            OP_REL_OFF: n_rel = 1'b0;
            OP_FORCE:   n_phase = r_pv;
            default: ;
        endcase
    end

    // Step operands: numerator magnitude is |amount| times a Q1.16 fraction.
    always_comb begin
        amt_neg = i_cfg.amt[AMT_W-1];
        amt_mag = amt_neg ? (AMT_W'(0) - i_cfg.amt) : i_cfg.amt;
        case (i_cmd.sel)
            SEL_ATT: begin
                x_sel   = UNITY_Q16;
                len_sel = r_att_left;
            end
            SEL_DEC: begin
                x_sel   = UNITY_Q16 - X_W'(i_cfg.sus);
                len_sel = r_dec_left;
            end
            SEL_REL: begin
                x_sel   = X_W'(i_cfg.sus);
                len_sel = r_rel_left;
            end
            default: begin
                x_sel   = '0;
                len_sel = '0;
            end
        endcase
        // Scale by 2^F and drop the 16 fraction bits of the sustain factor.
        wide    = WIDE_W'(r_prod) << FRAC_BITS;
        div_num = wide[WIDE_W-1:16];
    end

    ladsr_div #(
        .NUM_W (MAG_W),
        .DEN_W (LEN_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (len_sel),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // Sign and saturation of the truncated quotient; a zero length gives a zero step.
    always_comb begin
        q_ext = QX_W'(div_quo);
        if (len_sel == '0) begin
            step_val = '0;
        end else if (amt_neg) begin
            step_val = (q_ext > QLIM_NEG) ? SAT_LO[W25-1:0] : W25'(QX_W'(0) - q_ext);
        end else begin
            step_val = (q_ext > QLIM_POS) ? SAT_HI[W25-1:0] : W25'(q_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op <= i_op;
            r_pv <= i_phase_value;
        end
        if (i_cmd.mul_load) begin
            r_prod <= PROD_W'(amt_mag) * PROD_W'(x_sel);
        end
        if (i_cmd.exec) begin
            r_cut       <= sat25(cut_sum);
            r_out_phase <= n_phase;
            r_out_rel   <= n_rel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SUSTAIN;
            r_rel       <= 1'b0;
            r_offset    <= '0;
            r_att_left  <= '0;
            r_dec_left  <= '0;
            r_rel_left  <= '0;
            r_att_step  <= '0;
            r_dec_step  <= '0;
            r_rel_step  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_phase     <= n_phase;
                r_rel       <= n_rel;
                r_offset    <= n_offset;
                r_att_left  <= n_att_left;
                r_dec_left  <= n_dec_left;
                r_rel_left  <= n_rel_left;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.step_store) begin
                case (i_cmd.sel)
                    SEL_ATT: r_att_step <= step_val;
                    SEL_DEC: r_dec_step <= step_val;
                    SEL_REL: r_rel_step <= step_val;
                    default: ;
                endcase
            end
        end
    end

    assign o_status.out_free   = !r_out_valid || !i_out_stall;
    assign o_status.note_start = (r_op == OP_NOTE);
    assign o_status.div_done   = div_done;

    assign o_out_valid      = r_out_valid;
    assign o_cutoff_q8      = r_cut;
    assign o_phase          = r_out_phase;
    assign o_release_active = r_out_rel;

endmodule

FILE: sv/ladsr_ctrl.sv
// Controller for the envelope: takes a transaction, applies it, and on a
// note start sequences the three step divisions. Uses ladsr_pkg and the assert macros.
`include "linear_adsr_cutoff_envelope_top_assert.svh"
module ladsr_ctrl
    import ladsr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DSTART = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_STORE  = 3'd5;

    logic [2:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;

    always_comb begin
        n_state          = r_state;
        n_sel            = r_sel;
        o_cmd.accept     = 1'b0;
        o_cmd.exec       = 1'b0;
        o_cmd.mul_load   = 1'b0;
        o_cmd.div_start  = 1'b0;
        o_cmd.step_store = 1'b0;
        o_cmd.sel        = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                // The result goes out with the state update, so wait for room.
                if (i_status.out_free) begin
                    o_cmd.exec = 1'b1;
                    if (i_status.note_start) begin
                        n_state = S_MUL;
                        n_sel   = SEL_ATT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.step_store = 1'b1;
                if (r_sel == SEL_REL) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_MUL;
                    n_sel   = r_sel + 2'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= SEL_ATT;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    `LADSR_ASSERT_IMP(a_exec_has_room, i_clk, i_rst_n, o_cmd.exec, i_status.out_free, "exec issued while the result register is held")
    `LADSR_ASSERT_NXT(a_div_start_clears, i_clk, i_rst_n, o_cmd.div_start, (!i_status.div_done && r_state == S_DIV), "divider done not cleared by start")
    `LADSR_ASSERT_IMP(a_store_sel_legal, i_clk, i_rst_n, o_cmd.step_store, (r_sel == SEL_ATT || r_sel == SEL_DEC || r_sel == SEL_REL), "step store with an unknown step select")
    `LADSR_ASSERT_NXT(a_note_runs_steps, i_clk, i_rst_n, (o_cmd.exec && i_status.note_start), (r_state == S_MUL && r_sel == SEL_ATT), "note start did not begin the step sequence")

endmodule

FILE: tb/tb_linear_adsr_cutoff_envelope_top.sv
// Self-checking testbench for the linear ADSR cutoff envelope: directed and random transactions
// on both handshake channels, with every result compared against a cycle-free envelope model.
// Depends on ladsr_pkg and linear_adsr_cutoff_envelope_top.
`timescale 1ns / 100ps

module tb_linear_adsr_cutoff_envelope_top;
    import ladsr_pkg::*;

    localparam int LEN_BITS       = 20;
    localparam int FRAC_BITS      = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 6;
    localparam int RANDOM_ITEMS   = 340;

    localparam longint CUT_MAX = (longint'(1) << (W25 - 1)) - 1;
    localparam longint CUT_MIN = -(longint'(1) << (W25 - 1));

    // Register indexes past the end of the list; writes to them are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(CFG_RELEASE + 1);
    // Op codes with no function; they still return a result.
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_W'(OP_FORCE + 1);
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = '1;

    typedef struct packed {
        logic [W25-1:0]  cutoff;
        logic [PH_W-1:0] phase;
        logic            release_active;
    } t_envelope_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_op = OP_TICK;
    logic [PH_W-1:0]       i_phase_value = PH_ATTACK;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic signed [W25-1:0] o_cutoff_q8;
    logic [PH_W-1:0]       o_phase;
    logic                  o_release_active;

    // Envelope model: settings and state.
    logic [BASE_W-1:0]        cfg_base;
    logic signed [AMT_W-1:0]  cfg_amount;
    logic [SUS_W-1:0]         cfg_sustain;
    logic [LEN_CFG_W-1:0]     cfg_att_len;
    logic [LEN_CFG_W-1:0]     cfg_dec_len;
    logic [LEN_CFG_W-1:0]     cfg_rel_len;
    logic [PH_W-1:0]          env_phase;
    logic                     rel_flag;
    logic signed [W25-1:0]    env_offset;
    logic signed [W25-1:0]    att_step;
    logic signed [W25-1:0]    dec_step;
    logic signed [W25-1:0]    rel_step;
    logic [LEN_BITS-1:0]      att_left;
    logic [LEN_BITS-1:0]      dec_left;
    logic [LEN_BITS-1:0]      rel_left;

    t_envelope_out pending_results[$];
    t_envelope_out head_result;

    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned items_sent = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_run = 0;
    bit          send_gaps = 1'b1;
    bit          stall_on = 1'b1;

    linear_adsr_cutoff_envelope_top #(
        .LEN_BITS  (LEN_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_phase_value    (i_phase_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cutoff_q8      (o_cutoff_q8),
        .o_phase          (o_phase),
        .o_release_active (o_release_active)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic signed [W25-1:0] clip25(input longint v);
        if (v > CUT_MAX) return W25'(CUT_MAX);
        if (v < CUT_MIN) return W25'(CUT_MIN);
        return W25'(v);
    endfunction

    function automatic logic [LEN_BITS-1:0] tick_down(input logic [LEN_BITS-1:0] c);
        return (c == 0) ? c : c - LEN_BITS'(1);
    endfunction

    // Per-sample step: a Q.16 Hz amount spread over len samples, truncated toward zero.
    function automatic logic signed [W25-1:0] segment_step(input longint num_q16,
                                                          input logic [LEN_BITS-1:0] len);
        if (len == 0) return '0;
        return clip25((num_q16 * (longint'(1) << FRAC_BITS))
                      / (longint'(len) * longint'(UNITY_Q16)));
    endfunction

    function automatic t_envelope_out envelope_advance(input logic [OP_W-1:0] op,
                                                       input logic [PH_W-1:0] pv);
        t_envelope_out res;
        longint amt;
        longint sus;
        amt = longint'(cfg_amount);
        sus = longint'(cfg_sustain);
        // The reported cutoff is the one from before this transaction.
        res.cutoff = clip25(longint'(cfg_base) * (longint'(1) << FRAC_BITS)
                            + longint'(env_offset));
        case (op)
            OP_TICK: begin
                case (env_phase)
                    PH_ATTACK: begin
                        env_offset = clip25(longint'(env_offset) + longint'(att_step));
                        if (att_left <= 1) env_phase = PH_DECAY;
                        att_left = tick_down(att_left);
                    end
                    PH_DECAY: begin
                        env_offset = clip25(longint'(env_offset) - longint'(dec_step));
                        if (dec_left <= 1) env_phase = PH_SUSTAIN;
                        dec_left = tick_down(dec_left);
                    end
                    PH_SUSTAIN: begin
                        if (rel_flag) env_phase = PH_RELEASE;
                    end
                    default: begin
                        // Release only moves the offset while the flag is still set.
                        if (rel_flag) env_offset = clip25(longint'(env_offset)
                                                          - longint'(rel_step));
                        if (rel_left <= 1) rel_flag = 1'b0;
                        rel_left = tick_down(rel_left);
                    end
                endcase
            end
            OP_NOTE: begin
                env_offset = '0;
                env_phase  = PH_ATTACK;
                att_left   = LEN_BITS'(cfg_att_len);
                dec_left   = LEN_BITS'(cfg_dec_len);
                rel_left   = LEN_BITS'(cfg_rel_len);
                att_step   = segment_step(amt * longint'(UNITY_Q16), att_left);
                dec_step   = segment_step(amt * (longint'(UNITY_Q16) - sus), dec_left);
                rel_step   = segment_step(amt * sus, rel_left);
            end
            OP_REL_ON:  rel_flag = 1'b1;
            OP_REL_OFF: rel_flag = 1'b0;
            OP_FORCE:   env_phase = pv;
            default: ;
        endcase
        res.phase          = env_phase;
        res.release_active = rel_flag;
        return res;
    endfunction

    // Result check first, then the new transaction and register write of this edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_base    = 15'd1000;
            cfg_amount  = '0;
            cfg_sustain = 16'h8000;
            cfg_att_len = '0;
            cfg_dec_len = '0;
            cfg_rel_len = '0;
            env_phase   = PH_SUSTAIN;
            rel_flag    = 1'b0;
            env_offset  = '0;
            att_step    = '0;
            dec_step    = '0;
            rel_step    = '0;
            att_left    = '0;
            dec_left    = '0;
            rel_left    = '0;
            pending_results.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    fail_count++;
                end else begin
                    head_result = pending_results.pop_front();
                    if (o_cutoff_q8 !== head_result.cutoff) begin
                        $error("cutoff_q8 mismatch: expected %0d, actual %0d",
                               $signed(head_result.cutoff), o_cutoff_q8);
                        fail_count++;
                    end
                    if (o_phase !== head_result.phase) begin
                        $error("phase mismatch: expected %0d, actual %0d",
                               head_result.phase, o_phase);
                        fail_count++;
                    end
                    if (o_release_active !== head_result.release_active) begin
                        $error("release_active mismatch: expected %0d, actual %0d",
                               head_result.release_active, o_release_active);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall)
                pending_results.push_back(envelope_advance(i_op, i_phase_value));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE:    cfg_base    = i_cfg_data[BASE_W-1:0];
                    CFG_AMOUNT:  cfg_amount  = i_cfg_data[AMT_W-1:0];
                    CFG_SUSTAIN: cfg_sustain = i_cfg_data[SUS_W-1:0];
                    CFG_ATTACK:  cfg_att_len = i_cfg_data[LEN_CFG_W-1:0];
                    CFG_DECAY:   cfg_dec_len = i_cfg_data[LEN_CFG_W-1:0];
                    CFG_RELEASE: cfg_rel_len = i_cfg_data[LEN_CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Output stall: random runs, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_left == 0 && hold_served != hold_reqs) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!stall_on) begin
            i_out_stall <= 1'b0;
        end else if (stall_run != 0) begin
            stall_run--;
        end else begin
            i_out_stall <= ($urandom_range(0, 2) == 0);
            stall_run = idle_span();
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Valid stays high between back-to-back transactions; this task only drops it for a gap.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [PH_W-1:0] pv);
        int unsigned gap;
        gap = send_gaps ? idle_span() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_phase_value <= pv;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    task automatic send_tick_or_noise();
        if ($urandom_range(0, 99) < 85)
            send_item(OP_TICK, PH_W'($urandom));
        else
            send_item(OP_W'($urandom_range(0, 7)), PH_W'($urandom));
    endtask

    // Waits until every result is out and the block has finished any step computation.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || o_in_stall) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all six registers and one index past the list, then releases the port.
    task automatic program_envelope(input logic [CFG_DATA_W-1:0] base_w, amount_w, sustain_w,
                                    input logic [CFG_DATA_W-1:0] att_w, dec_w, rel_w);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_BASE;
        i_cfg_data <= base_w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_AMOUNT;
        i_cfg_data <= amount_w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SUSTAIN;
        i_cfg_data <= sustain_w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ATTACK;
        i_cfg_data <= att_w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_DECAY;
        i_cfg_data <= dec_w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_RELEASE;
        i_cfg_data <= rel_w;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SPARE | CFG_IDX_W'($urandom_range(0, 1));
        i_cfg_data <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random register word; bits above the field are random as the block must drop them.
    function automatic logic [CFG_DATA_W-1:0] pick_word(input int unsigned field_w,
                                                        input int unsigned typical_hi);
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] field_mask;
        w = CFG_DATA_W'($urandom);
        field_mask = (CFG_DATA_W'(1) << field_w) - CFG_DATA_W'(1);
        case ($urandom_range(0, 9))
            0: w = w | field_mask;
            1: w = w & ~field_mask;
            2: w = (w & ~field_mask) | (field_mask >> 1);
            3: w = (w & ~field_mask) | ((field_mask >> 1) + CFG_DATA_W'(1));
            4: ;
            default: w = (w & ~field_mask) | CFG_DATA_W'($urandom_range(0, typical_hi));
        endcase
        return w;
    endfunction

    // Mostly short segments so whole envelopes play out; now and then zero or huge.
    function automatic logic [CFG_DATA_W-1:0] pick_len();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return '1;
            2: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic check_reset_defaults();
        send_item(OP_TICK, PH_ATTACK);
        send_item(OP_UNUSED_FIRST, PH_RELEASE);
        send_item(OP_UNUSED_LAST, PH_DECAY);
        send_item(OP_TICK, PH_SUSTAIN);
        wait_idle();
    endtask

    // Zero-length segments end on their first tick with a zero step.
    task automatic check_zero_lengths();
        program_envelope(20'd1000, 20'd2000, 20'd32768, 20'd0, 20'd0, 20'd0);
        send_item(OP_NOTE, PH_ATTACK);
        send_item(OP_TICK, PH_ATTACK);
        send_item(OP_TICK, PH_ATTACK);
        send_item(OP_REL_ON, PH_ATTACK);
        send_item(OP_TICK, PH_ATTACK);
        send_item(OP_TICK, PH_ATTACK);
        wait_idle();
    endtask

    task automatic check_full_envelope();
        program_envelope(20'd2000, 20'd24000, 20'd16384, 20'd2, 20'd1, 20'd2);
        send_item(OP_NOTE, PH_SUSTAIN);
        repeat (3) send_item(OP_TICK, PH_ATTACK);
        send_item(OP_REL_ON, PH_ATTACK);
        // Sustain to release, two release ticks, then one more after the flag cleared.
        repeat (4) send_item(OP_TICK, PH_ATTACK);
        send_item(OP_REL_OFF, PH_ATTACK);
        send_item(OP_FORCE, PH_DECAY);
        send_item(OP_FORCE, PH_RELEASE);
        wait_idle();
    endtask

    // Largest base and amount with one-sample segments push offset and cutoff into saturation.
    task automatic check_saturation();
        program_envelope(20'h07FFF, 20'h07FFF, 20'h00000, 20'd1, 20'd1, 20'd1);
        send_item(OP_NOTE, PH_RELEASE);
        send_item(OP_TICK, PH_ATTACK);
        send_item(OP_FORCE, PH_ATTACK);
        send_item(OP_TICK, PH_ATTACK);
        send_item(OP_FORCE, PH_ATTACK);
        send_item(OP_TICK, PH_ATTACK);
        send_item(OP_TICK, PH_ATTACK);
        wait_idle();
    endtask

    task automatic check_backpressure();
        program_envelope(20'd12000, 20'h08000, 20'd65535, 20'd6, 20'd5, 20'd4);
        send_gaps = 1'b0;
        hold_reqs++;
        send_item(OP_NOTE, PH_ATTACK);
        repeat (8) send_item(OP_TICK, PH_ATTACK);
        send_item(OP_REL_ON, PH_ATTACK);
        repeat (8) send_item(OP_TICK, PH_ATTACK);
        wait_idle();
        send_gaps = 1'b1;
    endtask

    task automatic check_random_notes();
        int unsigned target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            wait_idle();
            send_gaps = ($urandom_range(0, 3) != 0);
            stall_on  = ($urandom_range(0, 3) != 0);
            program_envelope(pick_word(BASE_W, 24000), pick_word(AMT_W, 65535),
                             pick_word(SUS_W, 65535), pick_len(), pick_len(), pick_len());
            repeat ($urandom_range(1, 3)) begin
                send_item(OP_NOTE, PH_W'($urandom));
                repeat ($urandom_range(0, 12)) send_tick_or_noise();
                if ($urandom_range(0, 3) != 0) send_item(OP_REL_ON, PH_W'($urandom));
                repeat ($urandom_range(0, 10)) send_tick_or_noise();
                if ($urandom_range(0, 4) == 0) send_item(OP_REL_OFF, PH_W'($urandom));
            end
        end
        send_gaps = 1'b1;
        stall_on  = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_reset_defaults();
        check_zero_lengths();
        check_full_envelope();
        check_saturation();
        check_backpressure();
        check_random_notes();
        wait_idle();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
